// ----- sv/lgc_pkg.sv -----
// Shared constants, register codes and sizing functions for the linear gradient color core.
`timescale 1ns / 1ps
`default_nettype none

package lgc_pkg;

  // Default sizes
  localparam int COORD_BITS_DEF   = 16;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int COORD_USE_MAX    = 30;

  // Fraction bits of the gradient parameter t
  localparam int T_FRAC = 16;

  // Register index codes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_START_X     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_END_X       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_Y       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_COLOR = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_COLOR   = 3'd5;

  // How t is formed at the end of the divider
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] T_MODE_DIV  = 2'd0;
  localparam logic [MODE_W-1:0] T_MODE_ZERO = 2'd1;
  localparam logic [MODE_W-1:0] T_MODE_ONE  = 2'd2;

  // Coordinate bits that take part in the math
  function automatic int coord_use(input int coord_bits);
    return (coord_bits > COORD_USE_MAX) ? COORD_USE_MAX : coord_bits;
  endfunction

  // Configuration data width: 64 once a color word no longer fits in 32 bits
  function automatic int cfg_data_w(input int channel_bits);
    return (4 * channel_bits > 32) ? 64 : 32;
  endfunction

  // Byte address width: register index plus the byte offset of one word
  function automatic int cfg_addr_w(input int channel_bits);
    return REG_IDX_W + ((cfg_data_w(channel_bits) == 64) ? 3 : 2);
  endfunction

endpackage

`default_nettype wire

// ----- sv/lgc_if.sv -----
// Request channel interfaces: query points in, interpolated colors out.
`timescale 1ns / 1ps
`default_nettype none

interface lgc_in_if #(
  parameter int COORD_BITS = lgc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface lgc_out_if #(
  parameter int CHANNEL_BITS = lgc_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  logic [CHANNEL_BITS-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/lgc_regs.sv -----
// APB-style configuration registers: gradient end points and colors.
`timescale 1ns / 1ps
`default_nettype none

module lgc_regs #(
  parameter int COORD_BITS   = lgc_pkg::COORD_BITS_DEF,
  parameter int CHANNEL_BITS = lgc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [lgc_pkg::cfg_addr_w(CHANNEL_BITS)-1:0]  paddr,
  input  logic [lgc_pkg::cfg_data_w(CHANNEL_BITS)-1:0]  pwdata,
  output logic [lgc_pkg::cfg_data_w(CHANNEL_BITS)-1:0]  prdata,
  output logic                                          pready,
  output logic [COORD_BITS-1:0]                         start_x,
  output logic [COORD_BITS-1:0]                         start_y,
  output logic [COORD_BITS-1:0]                         end_x,
  output logic [COORD_BITS-1:0]                         end_y,
  output logic [4*CHANNEL_BITS-1:0]                     start_color,
  output logic [4*CHANNEL_BITS-1:0]                     end_color
);
  import lgc_pkg::*;

  localparam int DW    = cfg_data_w(CHANNEL_BITS);
  localparam int AW    = cfg_addr_w(CHANNEL_BITS);
  localparam int COL_W = 4 * CHANNEL_BITS;

  logic [COORD_BITS-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [COL_W-1:0]      start_color_r, end_color_r;
  logic [REG_IDX_W-1:0]  idx;
  logic                  wr_en;

  assign idx    = paddr[AW-1:AW-REG_IDX_W];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r     <= '0;
      start_y_r     <= '0;
      end_x_r       <= '0;
      end_y_r       <= '0;
      start_color_r <= '0;
      end_color_r   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_X:     start_x_r     <= pwdata[COORD_BITS-1:0];
        REG_START_Y:     start_y_r     <= pwdata[COORD_BITS-1:0];
        REG_END_X:       end_x_r       <= pwdata[COORD_BITS-1:0];
        REG_END_Y:       end_y_r       <= pwdata[COORD_BITS-1:0];
        REG_START_COLOR: start_color_r <= pwdata[COL_W-1:0];
        REG_END_COLOR:   end_color_r   <= pwdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_START_X:     prdata = DW'(start_x_r);
      REG_START_Y:     prdata = DW'(start_y_r);
      REG_END_X:       prdata = DW'(end_x_r);
      REG_END_Y:       prdata = DW'(end_y_r);
      REG_START_COLOR: prdata = DW'(start_color_r);
      REG_END_COLOR:   prdata = DW'(end_color_r);
      default:         prdata = '0;
    endcase
  end

  assign start_x     = start_x_r;
  assign start_y     = start_y_r;
  assign end_x       = end_x_r;
  assign end_y       = end_y_r;
  assign start_color = start_color_r;
  assign end_color   = end_color_r;

endmodule

`default_nettype wire

// ----- sv/lgc_proj.sv -----
// Projection front end: differences, products, dot products and the t-case split.
`timescale 1ns / 1ps
`default_nettype none

module lgc_proj #(
  parameter int COORD_BITS = lgc_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          up_valid,
  output logic                                          up_ready,
  input  logic [COORD_BITS-1:0]                         pos_x,
  input  logic [COORD_BITS-1:0]                         pos_y,
  input  logic [COORD_BITS-1:0]                         start_x,
  input  logic [COORD_BITS-1:0]                         start_y,
  input  logic [COORD_BITS-1:0]                         end_x,
  input  logic [COORD_BITS-1:0]                         end_y,
  output logic                                          dn_valid,
  input  logic                                          dn_ready,
  output logic [lgc_pkg::MODE_W-1:0]                    dn_mode,
  output logic [2*lgc_pkg::coord_use(COORD_BITS)+1:0]   dn_rem,
  output logic [2*lgc_pkg::coord_use(COORD_BITS)+1:0]   dn_den
);
  import lgc_pkg::*;

  localparam int CU     = coord_use(COORD_BITS);
  localparam int DIFF_W = CU + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DEN_W  = PROD_W;
  localparam int NUM_W  = PROD_W + 1;

  logic v0_r, v1_r, v2_r, v3_r;
  logic en0, en1, en2, en3;

  logic signed [DIFF_W-1:0] px, py, sx, sy, ex, ey;
  logic signed [DIFF_W-1:0] rx_r, ry_r, dx_r, dy_r;
  logic signed [PROD_W-1:0] prx_r, pry_r, pdx_r, pdy_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]         den_r;
  logic [MODE_W-1:0]        mode_r, mode_nxt;
  logic [DEN_W-1:0]         rem_r, den3_r;

  // Bubble-collapsing stall chain
  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign up_ready = en0;

  // Sign-extend the coordinate bits that take part
  assign px = DIFF_W'($signed(pos_x[CU-1:0]));
  assign py = DIFF_W'($signed(pos_y[CU-1:0]));
  assign sx = DIFF_W'($signed(start_x[CU-1:0]));
  assign sy = DIFF_W'($signed(start_y[CU-1:0]));
  assign ex = DIFF_W'($signed(end_x[CU-1:0]));
  assign ey = DIFF_W'($signed(end_y[CU-1:0]));

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en0) v0_r <= up_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Stage 0: offsets from the start point and the gradient direction
  always_ff @(posedge clk) begin
    if (en0) begin
      rx_r <= px - sx;
      ry_r <= py - sy;
      dx_r <= ex - sx;
      dy_r <= ey - sy;
    end
  end

  // Stage 1: the four products
  always_ff @(posedge clk) begin
    if (en1) begin
      prx_r <= PROD_W'(rx_r) * PROD_W'(dx_r);
      pry_r <= PROD_W'(ry_r) * PROD_W'(dy_r);
      pdx_r <= PROD_W'(dx_r) * PROD_W'(dx_r);
      pdy_r <= PROD_W'(dy_r) * PROD_W'(dy_r);
    end
  end

  // Stage 2: dot product and squared length
  always_ff @(posedge clk) begin
    if (en2) begin
      num_r <= NUM_W'(prx_r) + NUM_W'(pry_r);
      den_r <= $unsigned(pdx_r) + $unsigned(pdy_r);
    end
  end

  // Stage 3: clamp before the start, past the end, or divide
  always_comb begin
    priority if (den_r == '0 || num_r[NUM_W-1] || num_r == '0) begin
      mode_nxt = T_MODE_ZERO;
    end else if (num_r >= $signed({1'b0, den_r})) begin
      mode_nxt = T_MODE_ONE;
    end else begin
      mode_nxt = T_MODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      mode_r <= mode_nxt;
      rem_r  <= num_r[DEN_W-1:0];
      den3_r <= den_r;
    end
  end

  assign dn_valid = v3_r;
  assign dn_mode  = mode_r;
  assign dn_rem   = rem_r;
  assign dn_den   = den3_r;

endmodule

`default_nettype wire

// ----- sv/lgc_div.sv -----
// Pipelined restoring divider: one quotient bit of t per stage.
`timescale 1ns / 1ps
`default_nettype none

module lgc_div #(
  parameter int COORD_BITS = lgc_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          up_valid,
  output logic                                          up_ready,
  input  logic [lgc_pkg::MODE_W-1:0]                    up_mode,
  input  logic [2*lgc_pkg::coord_use(COORD_BITS)+1:0]   up_rem,
  input  logic [2*lgc_pkg::coord_use(COORD_BITS)+1:0]   up_den,
  output logic                                          dn_valid,
  input  logic                                          dn_ready,
  output logic [lgc_pkg::MODE_W-1:0]                    dn_mode,
  output logic [lgc_pkg::T_FRAC-1:0]                    dn_q
);
  import lgc_pkg::*;

  localparam int DEN_W = 2 * coord_use(COORD_BITS) + 2;

  logic [T_FRAC-1:0] v_r;
  logic [T_FRAC:0]   en;
  logic [MODE_W-1:0] mode_r [T_FRAC];
  logic [T_FRAC-1:0] q_r    [T_FRAC];
  logic [DEN_W-1:0]  rem_r  [T_FRAC-1];
  logic [DEN_W-1:0]  den_r  [T_FRAC-1];

  assign en[T_FRAC] = dn_ready;
  assign up_ready   = en[0];

  for (genvar i = 0; i < T_FRAC; i++) begin : g_stage
    logic              src_v;
    logic [MODE_W-1:0] src_mode;
    logic [T_FRAC-1:0] src_q;
    logic [DEN_W-1:0]  src_rem, src_den;
    logic [DEN_W:0]    sh, dif;
    logic              ge;

    // Take the previous stage, or the request for the first one
    if (i == 0) begin : g_first
      assign src_v    = up_valid;
      assign src_mode = up_mode;
      assign src_q    = '0;
      assign src_rem  = up_rem;
      assign src_den  = up_den;
    end else begin : g_next
      assign src_v    = v_r[i-1];
      assign src_mode = mode_r[i-1];
      assign src_q    = q_r[i-1];
      assign src_rem  = rem_r[i-1];
      assign src_den  = den_r[i-1];
    end

    assign en[i] = !v_r[i] || en[i+1];

    // Shift the remainder, subtract the divisor where it fits
    assign sh  = {src_rem, 1'b0};
    assign dif = sh - {1'b0, src_den};
    assign ge  = sh >= {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en[i]) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        mode_r[i] <= src_mode;
        q_r[i]    <= {src_q[T_FRAC-2:0], ge};
      end
    end

    // The last stage needs only the quotient bit
    if (i < T_FRAC - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[i]) begin
          rem_r[i] <= ge ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
          den_r[i] <= src_den;
        end
      end
    end
  end

  assign dn_valid = v_r[T_FRAC-1];
  assign dn_mode  = mode_r[T_FRAC-1];
  assign dn_q     = q_r[T_FRAC-1];

endmodule

`default_nettype wire

// ----- sv/lgc_blend.sv -----
// Color blend: weight start and end channels by t, round, and hold the result.
`timescale 1ns / 1ps
`default_nettype none

module lgc_blend #(
  parameter int CHANNEL_BITS = lgc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [lgc_pkg::MODE_W-1:0]    up_mode,
  input  logic [lgc_pkg::T_FRAC-1:0]    up_q,
  input  logic [4*CHANNEL_BITS-1:0]     start_color,
  input  logic [4*CHANNEL_BITS-1:0]     end_color,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [CHANNEL_BITS-1:0]       red,
  output logic [CHANNEL_BITS-1:0]       green,
  output logic [CHANNEL_BITS-1:0]       blue,
  output logic [CHANNEL_BITS-1:0]       alpha
);
  import lgc_pkg::*;

  localparam int TW    = T_FRAC + 1;
  localparam int PW    = CHANNEL_BITS + TW;
  localparam int SW    = PW + 1;
  localparam logic [TW-1:0] T_ONE_V = TW'(1) << T_FRAC;
  localparam logic [SW-1:0] HALF    = SW'(1) << (T_FRAC - 1);

  logic              va_r, vb_r;
  logic              en_a, en_b;
  logic [TW-1:0]     t, t_inv;
  logic [PW-1:0]     ps_r [4];
  logic [PW-1:0]     pe_r [4];
  logic [CHANNEL_BITS-1:0] ch_r [4];

  assign en_b     = !vb_r || dn_ready;
  assign en_a     = !va_r || en_b;
  assign up_ready = en_a;

  // Form t from the divider result
  always_comb begin
    unique case (up_mode)
      T_MODE_DIV:  t = {1'b0, up_q};
      T_MODE_ZERO: t = '0;
      T_MODE_ONE:  t = T_ONE_V;
      default:     t = '0;
    endcase
  end

  assign t_inv = T_ONE_V - t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= up_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_chan
    logic [CHANNEL_BITS-1:0] s_ch, e_ch;
    logic [SW-1:0]           sum;

    // Red sits in the top channel
    assign s_ch = start_color[(3-k)*CHANNEL_BITS +: CHANNEL_BITS];
    assign e_ch = end_color[(3-k)*CHANNEL_BITS +: CHANNEL_BITS];

    // Stage A: weight both end colors
    always_ff @(posedge clk) begin
      if (en_a) begin
        ps_r[k] <= PW'(s_ch) * PW'(t_inv);
        pe_r[k] <= PW'(e_ch) * PW'(t);
      end
    end

    // Stage B: add, round half up, drop the fraction
    assign sum = SW'(ps_r[k]) + SW'(pe_r[k]) + HALF;

    always_ff @(posedge clk) begin
      if (en_b) begin
        ch_r[k] <= sum[T_FRAC +: CHANNEL_BITS];
      end
    end
  end

  assign dn_valid = vb_r;
  assign red      = ch_r[0];
  assign green    = ch_r[1];
  assign blue     = ch_r[2];
  assign alpha    = ch_r[3];

endmodule

`default_nettype wire

// ----- sv/linear_gradient_color_core.sv -----
// Top level of the linear gradient color core.
`timescale 1ns / 1ps
`default_nettype none

// Linear gradient color core. Each request carries a point (pos_x, pos_y) in
// signed Q12.4; the core projects it onto the line from the start point to the
// end point, clamps the parameter t to [0,1] with 16 fraction bits, and returns
// the RGBA color start*(1-t) + end*t rounded half up, one result per request.
// Equal start and end points give the start color. The core takes one request
// every clock cycle unless result-side stalls hold it off; a request's result
// passes 22 register stages (4 projection stages, 16 divider stages, 2 blend
// stages), the depth being set by the divider, which forms one bit of t per
// stage. Stalls on the result side fill empty pipeline slots before holding
// off new requests. Program the registers only while no request is in flight:
// start_x, start_y, end_x, end_y, start_color, end_color at word offsets 0 to
// 5 (4-byte words, 8-byte once a color word exceeds 32 bits); writes beyond
// offset 5 are ignored.
module linear_gradient_color_core #(
  parameter int COORD_BITS   = lgc_pkg::COORD_BITS_DEF,
  parameter int CHANNEL_BITS = lgc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  lgc_in_if.sink                                        in_if,
  lgc_out_if.source                                     out_if,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [lgc_pkg::cfg_addr_w(CHANNEL_BITS)-1:0]  paddr,
  input  logic [lgc_pkg::cfg_data_w(CHANNEL_BITS)-1:0]  pwdata,
  output logic [lgc_pkg::cfg_data_w(CHANNEL_BITS)-1:0]  prdata,
  output logic                                          pready
);
  import lgc_pkg::*;

  localparam int DEN_W = 2 * coord_use(COORD_BITS) + 2;

  logic [COORD_BITS-1:0]     start_x, start_y, end_x, end_y;
  logic [4*CHANNEL_BITS-1:0] start_color, end_color;

  logic              proj_valid, proj_ready;
  logic [MODE_W-1:0] proj_mode;
  logic [DEN_W-1:0]  proj_rem, proj_den;

  logic              div_valid, div_ready;
  logic [MODE_W-1:0] div_mode;
  logic [T_FRAC-1:0] div_q;

  lgc_regs #(
    .COORD_BITS   (COORD_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .start_color (start_color),
    .end_color   (end_color)
  );

  lgc_proj #(
    .COORD_BITS (COORD_BITS)
  ) u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_if.valid),
    .up_ready (in_if.ready),
    .pos_x    (in_if.pos_x),
    .pos_y    (in_if.pos_y),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .dn_valid (proj_valid),
    .dn_ready (proj_ready),
    .dn_mode  (proj_mode),
    .dn_rem   (proj_rem),
    .dn_den   (proj_den)
  );

  lgc_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (proj_valid),
    .up_ready (proj_ready),
    .up_mode  (proj_mode),
    .up_rem   (proj_rem),
    .up_den   (proj_den),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_mode  (div_mode),
    .dn_q     (div_q)
  );

  lgc_blend #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (div_valid),
    .up_ready    (div_ready),
    .up_mode     (div_mode),
    .up_q        (div_q),
    .start_color (start_color),
    .end_color   (end_color),
    .dn_valid    (out_if.valid),
    .dn_ready    (out_if.ready),
    .red         (out_if.red),
    .green       (out_if.green),
    .blue        (out_if.blue),
    .alpha       (out_if.alpha)
  );

  // A request sent to the divider holds a remainder below the divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    proj_valid && proj_mode == T_MODE_DIV |-> proj_rem < proj_den)
    else $error("divider entered with remainder not below divisor");

  // A degenerate gradient never reaches the division path
  assert property (@(posedge clk) disable iff (!rst_n)
    proj_valid && proj_den == '0 |-> proj_mode == T_MODE_ZERO)
    else $error("zero-length gradient not forced to t = 0");

  // A stalled divider result holds until the blend stage takes it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_valid && !div_ready |=> div_valid && $stable(div_q) && $stable(div_mode))
    else $error("divider result changed while stalled");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the linear gradient color core.
`timescale 1ns / 1ps

module tb;
  import lgc_pkg::*;

  localparam int ADDR_W = cfg_addr_w(CHANNEL_BITS_DEF);
  localparam int DATA_W = cfg_data_w(CHANNEL_BITS_DEF);
  localparam longint T_ONE = longint'(1) << T_FRAC;
  // Offsets past the last register; writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_t;

  // One row of the directed table: a register write or a query point
  typedef struct {
    bit                      is_write;
    logic [REG_IDX_W-1:0]    idx;
    logic [31:0]             wdata;
    logic signed [15:0]      px;
    logic signed [15:0]      py;
    bit                      known;
    color_t                  color;
  } step_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  lgc_in_if  #(.COORD_BITS(COORD_BITS_DEF))     in_ch ();
  lgc_out_if #(.CHANNEL_BITS(CHANNEL_BITS_DEF)) out_ch ();

  linear_gradient_color_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the gradient registers
  logic signed [15:0] grad_start_x, grad_start_y, grad_end_x, grad_end_y;
  logic [31:0]        grad_start_color, grad_end_color;

  color_t pending_colors[$];
  int     mismatch_count;
  int     send_idle_pct;
  int     recv_idle_pct;

  step_t  dir_steps[$];

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Project the point onto the gradient line and blend the two colors
  function automatic color_t blend_color(input logic signed [15:0] px,
                                         input logic signed [15:0] py);
    longint dx, dy, rx, ry, num, den, t, s, e, v;
    logic [31:0] word;
    dx = longint'(grad_end_x) - longint'(grad_start_x);
    dy = longint'(grad_end_y) - longint'(grad_start_y);
    rx = longint'(px) - longint'(grad_start_x);
    ry = longint'(py) - longint'(grad_start_y);
    num = rx * dx + ry * dy;
    den = dx * dx + dy * dy;
    if (den == 0 || num <= 0) begin
      t = 0;
    end else if (num >= den) begin
      t = T_ONE;
    end else begin
      t = (num << T_FRAC) / den;
    end
    for (int k = 0; k < 4; k++) begin
      s = longint'(grad_start_color[31 - 8 * k -: 8]);
      e = longint'(grad_end_color[31 - 8 * k -: 8]);
      v = (s * (T_ONE - t) + e * t + (T_ONE >> 1)) >> T_FRAC;
      word[31 - 8 * k -: 8] = v[7:0];
    end
    return color_t'(word);
  endfunction

  // Write one register over the config port: setup cycle, then access cycle
  task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_X:     grad_start_x = value[15:0];
      REG_START_Y:     grad_start_y = value[15:0];
      REG_END_X:       grad_end_x = value[15:0];
      REG_END_Y:       grad_end_y = value[15:0];
      REG_START_COLOR: grad_start_color = value;
      REG_END_COLOR:   grad_end_color = value;
      default: ;
    endcase
    // Leave the port idle before the next transfer
    @(posedge clk);
  endtask

  // Drop valid and hold until every expected color has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // Offer one request; record its expected color once it is taken
  task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                            input bit known, input color_t known_color);
    color_t want;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    want = known ? known_color : blend_color(px, py);
    do @(posedge clk); while (!in_ch.ready);
    pending_colors = {pending_colors, want};
  endtask

  function automatic step_t write_row(input logic [REG_IDX_W-1:0] idx,
                                      input logic [31:0] value);
    step_t r;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.wdata    = value;
    r.px       = '0;
    r.py       = '0;
    r.known    = 1'b0;
    r.color    = '0;
    return r;
  endfunction

  function automatic step_t point_row(input int x, input int y, input bit known,
                                      input logic [31:0] color);
    step_t r;
    r.is_write = 1'b0;
    r.idx      = '0;
    r.wdata    = '0;
    r.px       = 16'(x);
    r.py       = 16'(y);
    r.known    = known;
    r.color    = color_t'(color);
    return r;
  endfunction

  // Coordinate around the span of a and b, clipped to the Q12.4 range
  function automatic logic signed [15:0] near_coord(input int a, input int b);
    int lo, hi, pad;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    pad = (hi - lo) / 4 + 32;
    lo  = lo - pad;
    hi  = hi + pad;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // Accept results with random stalls and compare against the oldest expectation
  always @(posedge clk) begin
    color_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected result %02x%02x%02x%02x",
                        out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha));
      end else begin
        want = pending_colors.pop_front();
        if (out_ch.red !== want.red)
          report_mismatch($sformatf("red got %0d want %0d", out_ch.red, want.red));
        if (out_ch.green !== want.green)
          report_mismatch($sformatf("green got %0d want %0d", out_ch.green, want.green));
        if (out_ch.blue !== want.blue)
          report_mismatch($sformatf("blue got %0d want %0d", out_ch.blue, want.blue));
        if (out_ch.alpha !== want.alpha)
          report_mismatch($sformatf("alpha got %0d want %0d", out_ch.alpha, want.alpha));
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Stimulus: directed table, then random segments under three idling mixes
  initial begin
    logic signed [15:0] sx, sy, ex, ey;
    logic [31:0]        sc, ec;
    in_ch.valid  = 1'b0;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    out_ch.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_n        = 1'b0;
    mismatch_count   = 0;
    grad_start_x     = '0;
    grad_start_y     = '0;
    grad_end_x       = '0;
    grad_end_y       = '0;
    grad_start_color = '0;
    grad_end_color   = '0;
    send_idle_pct    = 27;
    recv_idle_pct    = 66;

    dir_steps = '{
      // all registers zero after reset: black everywhere
      point_row(0, 0, 1'b1, 32'h0),
      point_row(32767, -32768, 1'b1, 32'h0),
      // equal start and end points give the start color
      write_row(REG_START_COLOR, 32'h11223344),
      write_row(REG_END_COLOR, 32'hAABBCCDD),
      point_row(100, -100, 1'b1, 32'h11223344),
      // horizontal gradient from x = -10.0 to x = 10.0
      write_row(REG_START_X, 32'hFFFFFF60),
      write_row(REG_END_X, 32'h000000A0),
      point_row(-32768, 0, 1'b1, 32'h11223344),
      point_row(32767, 5, 1'b1, 32'hAABBCCDD),
      point_row(-160, 32767, 1'b1, 32'h11223344),
      point_row(160, -32768, 1'b1, 32'hAABBCCDD),
      point_row(0, 0, 1'b0, 32'h0),
      point_row(1, 1, 1'b0, 32'h0),
      point_row(-1, -1, 1'b0, 32'h0),
      point_row(80, 7, 1'b0, 32'h0),
      // writes past the last register are ignored
      write_row(REG_UNMAPPED_LO, 32'hFFFFFFFF),
      write_row(REG_UNMAPPED_HI, 32'hFFFFFFFF),
      point_row(0, 0, 1'b0, 32'h0),
      // full-range diagonal, black to white
      write_row(REG_START_X, 32'hFFFF8000),
      write_row(REG_START_Y, 32'hFFFF8000),
      write_row(REG_END_X, 32'h00007FFF),
      write_row(REG_END_Y, 32'h00007FFF),
      write_row(REG_START_COLOR, 32'h00000000),
      write_row(REG_END_COLOR, 32'hFFFFFFFF),
      point_row(32767, 32767, 1'b1, 32'hFFFFFFFF),
      point_row(-32768, -32768, 1'b1, 32'h0),
      point_row(0, 0, 1'b0, 32'h0),
      point_row(32767, -32768, 1'b0, 32'h0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; register writes wait for an idle core
    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_write) begin
        drain();
        program_reg(dir_steps[i].idx, dir_steps[i].wdata);
      end else begin
        send_point(dir_steps[i].px, dir_steps[i].py, dir_steps[i].known, dir_steps[i].color);
      end
    end

    for (int seg = 0; seg < 6; seg++) begin
      // two segments per idling mix: sender light, then receiver light, then none
      if (seg < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 66;
      end else if (seg < 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sx = 16'($urandom_range(65535));
      sy = 16'($urandom_range(65535));
      ex = 16'($urandom_range(65535));
      ey = 16'($urandom_range(65535));
      sc = $urandom();
      ec = $urandom();
      case (seg)
        0: begin
          sx = 16'sh7FFF;
          sy = 16'sh8000;
          ex = 16'sh8000;
          ey = 16'sh7FFF;
          sc = 32'hFFFFFFFF;
          ec = 32'h00000000;
        end
        2: begin
          ex = sx;
          ey = sy;
        end
        3: begin
          ex = near_coord(sx, sx);
          ey = near_coord(sy, sy);
        end
        4: begin
          sx = 16'sh8000;
          sy = 16'sh7FFF;
          ex = 16'sh7FFF;
          ey = 16'sh8000;
        end
        default: ;
      endcase
      drain();
      program_reg(REG_START_X, {{16{sx[15]}}, sx});
      program_reg(REG_START_Y, {{16{sy[15]}}, sy});
      program_reg(REG_END_X, {{16{ex[15]}}, ex});
      program_reg(REG_END_Y, {{16{ey[15]}}, ey});
      program_reg(REG_START_COLOR, sc);
      program_reg(REG_END_COLOR, ec);
      for (int n = 0; n < 80; n++) begin
        // hold the sender once until the pipeline has emptied
        if (seg == 1 && n == 40) drain();
        if ($urandom_range(3) == 0) begin
          send_point(16'($urandom_range(65535)), 16'($urandom_range(65535)), 1'b0, '0);
        end else begin
          send_point(near_coord(sx, ex), near_coord(sy, ey), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
